/* src/mm64_pkg.sv */
package mm64_pkg;

  // Mixing multiplier and shift distance of the hash
  localparam logic [63:0] MUL_CONST = 64'hc6a4a7935bd1e995;
  localparam int unsigned SHIFT_AMT = 47;

  // Configuration address: one 64-bit register, 8-byte stride
  localparam int unsigned CFG_AW = 4;
  localparam logic        REG_SEED = 1'b0;

  // Source of the multiplier operand register
  typedef enum logic [2:0] {
    M_LEN,
    M_WORD,
    M_MIXED,
    M_HXOR,
    M_TAILX,
    M_FIN
  } m_sel_t;

  // Source of the running hash register
  typedef enum logic {
    H_SEED,
    H_PROD
  } h_sel_t;

  // Step of the shared 32x32 multiplier
  typedef enum logic [1:0] {
    MS_NONE,
    MS_LO,
    MS_HI_A,
    MS_HI_B
  } mul_step_t;

  typedef struct packed {
    logic      latch;
    logic      m_load;
    m_sel_t    m_sel;
    mul_step_t mul_step;
    logic      h_load;
    h_sel_t    h_sel;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full;
    logic tail;
    logic out_free;
  } dp_stat_t;

  // Keep the low cnt bytes of a tail word
  function automatic logic [63:0] tail_mask(input logic [3:0] cnt);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < cnt) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [63:0] xsh(input logic [63:0] v);
    return v ^ (v >> SHIFT_AMT);
  endfunction

endpackage

/* src/mm64_in_if.sv */
interface mm64_in_if;
  logic        valid;
  logic        ready;
  logic        first;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;
  logic [31:0] total_length;

  modport source (
    output valid, first, data_word, byte_count, last, total_length,
    input  ready
  );
  modport sink (
    input  valid, first, data_word, byte_count, last, total_length,
    output ready
  );
endinterface

/* src/mm64_out_if.sv */
interface mm64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (
    output valid, hash_value,
    input  ready
  );
  modport sink (
    input  valid, hash_value,
    output ready
  );
endinterface

/* src/mm64_datapath.sv */
module mm64_datapath
  import mm64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [63:0] seed,
  input  logic        in_first,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last,
  input  logic [31:0] in_total_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_value
);

  logic        first_r;
  logic        last_r;
  logic [63:0] word_r;
  logic [3:0]  count_r;
  logic [31:0] len_r;
  logic [63:0] m_r, m_nxt;
  logic [63:0] p_r, p_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] hash_r;
  logic        out_valid_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  // Capture the item beat
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      first_r <= in_first;
      last_r  <= in_last;
      word_r  <= in_data_word;
      count_r <= in_byte_count;
      len_r   <= in_total_length;
    end
  end

  // Shared 32x32 multiplier: low product, then two cross terms into the upper half
  assign mul_a = (cmd.mul_step == MS_HI_A) ? m_r[63:32] : m_r[31:0];
  assign mul_b = (cmd.mul_step == MS_HI_B) ? MUL_CONST[63:32] : MUL_CONST[31:0];
  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (cmd.mul_step)
      MS_LO:           p_nxt = mul_p;
      MS_HI_A, MS_HI_B: p_nxt = {p_r[63:32] + mul_p[31:0], p_r[31:0]};
      default:         p_nxt = p_r;
    endcase
  end

  // Select the next multiplier operand
  always_comb begin
    m_nxt = m_r;
    if (cmd.m_load) begin
      unique case (cmd.m_sel)
        M_LEN:   m_nxt = {32'b0, len_r};
        M_WORD:  m_nxt = word_r;
        M_MIXED: m_nxt = xsh(p_r);
        M_HXOR:  m_nxt = h_r ^ p_r;
        M_TAILX: m_nxt = h_r ^ (word_r & tail_mask(count_r));
        M_FIN:   m_nxt = xsh(h_r);
        default: m_nxt = m_r;
      endcase
    end
  end

  // Update the running hash
  always_comb begin
    h_nxt = h_r;
    if (cmd.h_load) begin
      unique case (cmd.h_sel)
        H_SEED:  h_nxt = seed ^ p_r;
        H_PROD:  h_nxt = p_r;
        default: h_nxt = h_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    p_r <= p_nxt;
    if (!rst_n) begin
      h_r <= '0;
    end else begin
      h_r <= h_nxt;
    end
  end

  // Output register: hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hash_r <= xsh(p_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;

  assign stat.first    = first_r;
  assign stat.last     = last_r;
  assign stat.full     = count_r[3];
  assign stat.tail     = !count_r[3] && (|count_r[2:0]);
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

/* src/mm64_ctrl.sv */
module mm64_ctrl
  import mm64_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_BODY,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_POST,
    S_FINCHK,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_LEN,
    PH_W1,
    PH_W2,
    PH_W3,
    PH_TAIL,
    PH_FIN
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    in_ready     = 1'b0;
    cmd.latch    = 1'b0;
    cmd.m_load   = 1'b0;
    cmd.m_sel    = M_LEN;
    cmd.mul_step = MS_NONE;
    cmd.h_load   = 1'b0;
    cmd.h_sel    = H_PROD;
    cmd.out_load = 1'b0;

    unique case (state_r)
      // Wait for an item beat
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_START;
        end
      end
      // On a first beat, start a message: length times multiplier
      S_START: begin
        if (stat.first) begin
          cmd.m_load = 1'b1;
          cmd.m_sel  = M_LEN;
          phase_nxt  = PH_LEN;
          state_nxt  = S_MUL0;
        end else begin
          state_nxt = S_BODY;
        end
      end
      // Fold in a full or tail word
      S_BODY: begin
        priority if (stat.full) begin
          cmd.m_load = 1'b1;
          cmd.m_sel  = M_WORD;
          phase_nxt  = PH_W1;
          state_nxt  = S_MUL0;
        end else if (stat.tail) begin
          cmd.m_load = 1'b1;
          cmd.m_sel  = M_TAILX;
          phase_nxt  = PH_TAIL;
          state_nxt  = S_MUL0;
        end else begin
          state_nxt = S_FINCHK;
        end
      end
      // Three multiplier steps per 64-bit product
      S_MUL0: begin
        cmd.mul_step = MS_LO;
        state_nxt    = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_step = MS_HI_A;
        state_nxt    = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_step = MS_HI_B;
        state_nxt    = S_POST;
      end
      // Use the product according to the phase
      S_POST: begin
        unique case (phase_r)
          PH_LEN: begin
            cmd.h_load = 1'b1;
            cmd.h_sel  = H_SEED;
            state_nxt  = S_BODY;
          end
          PH_W1: begin
            cmd.m_load = 1'b1;
            cmd.m_sel  = M_MIXED;
            phase_nxt  = PH_W2;
            state_nxt  = S_MUL0;
          end
          PH_W2: begin
            cmd.m_load = 1'b1;
            cmd.m_sel  = M_HXOR;
            phase_nxt  = PH_W3;
            state_nxt  = S_MUL0;
          end
          PH_W3, PH_TAIL: begin
            cmd.h_load = 1'b1;
            cmd.h_sel  = H_PROD;
            state_nxt  = S_FINCHK;
          end
          PH_FIN: begin
            state_nxt = S_EMIT;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      // Finalize on the last item
      S_FINCHK: begin
        if (stat.last) begin
          cmd.m_load = 1'b1;
          cmd.m_sel  = M_FIN;
          phase_nxt  = PH_FIN;
          state_nxt  = S_MUL0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // Hand the hash to the output register once it is free
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_LEN;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

/* src/murmur64a_stream_hash_core.sv */
// MurmurHash64A over a stream of little-endian 64-bit words.
// Input channel in_s: one beat per word with first, data_word, byte_count
// (8 or more full, 1-7 tail, 0 no data), last and total_length (read on a first beat).
// Output channel out_m: one hash_value beat per message, after its last beat.
// Configuration: APB write of the 64-bit seed at address 0; reads return it.
// Timing: one item at a time. An item runs through the length product on a
// first beat, the word, mixed and hash products for a full word or a tail
// product for a tail word, and the finalizing product on a last beat. Each
// 64-bit product runs as a low product and two cross terms through one shared
// 32x32 multiplier, which sets the rate.
// The result sits in an output register, so the next item is taken while a
// hash waits; if the receiver still stalls when the next hash is ready, the
// block holds in its emit step until the output register frees up.
// Reset clears the seed and the running hash to zero and empties the output.
module murmur64a_stream_hash_core
  import mm64_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mm64_in_if.sink           in_s,
  mm64_out_if.source        out_m,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [63:0] seed_r;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        cfg_wr;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr && (paddr[3] == REG_SEED)) begin
      seed_r <= pwdata;
    end
  end

  assign prdata = (paddr[3] == REG_SEED) ? seed_r : '0;

  mm64_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_s.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mm64_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .seed            (seed_r),
    .in_first        (in_s.first),
    .in_data_word    (in_s.data_word),
    .in_byte_count   (in_s.byte_count),
    .in_last         (in_s.last),
    .in_total_length (in_s.total_length),
    .out_valid       (out_m.valid),
    .out_ready       (out_m.ready),
    .out_hash_value  (out_m.hash_value)
  );

`ifndef SYNTHESIS
  // Never load a result over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_m.valid || out_m.ready))
    else $error("result loaded while output beat still pending");

  // An accepted beat closes the input until the item is done
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_s.valid && in_s.ready) |=> !in_s.ready)
    else $error("input taken again right after a beat");

  // A result appears only from a load by the controller
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_m.valid) |-> $past(cmd.out_load))
    else $error("output valid rose without a result load");
`endif

endmodule

/* tb/tb.sv */
module tb;
  import mm64_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [CFG_AW-1:0] SEED_ADDR = CFG_AW'({REG_SEED, 3'b000});

  typedef struct packed {
    logic        first;
    logic [63:0] word;
    logic [3:0]  count;
    logic        last;
    logic [31:0] length;
  } word_beat_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  mm64_in_if  in_if ();
  mm64_out_if out_if ();

  murmur64a_stream_hash_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_if),
    .out_m   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the block's seed and running hash
  logic [63:0] seed_shadow;
  logic [63:0] chain_hash;
  logic [63:0] pending_hash_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned beats_sent;
  int unsigned hashes_seen;
  int unsigned seeds_written;
  int unsigned err_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // End the run if traffic stops moving
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d hashes pending", LIMIT_CYCLES,
             pending_hash_q.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [63:0] mul_k(input logic [63:0] v);
    return v * MUL_CONST;
  endfunction

  function automatic logic [63:0] shift_fold(input logic [63:0] v);
    return v ^ (v >> SHIFT_AMT);
  endfunction

  // Advance the shadow hash by one beat; return 1 with the final hash on a last beat
  function automatic bit fold_beat(input word_beat_t b, output logic [63:0] digest);
    logic [63:0] h;
    logic [63:0] keep;
    h = chain_hash;
    if (b.first) h = seed_shadow ^ mul_k({32'd0, b.length});
    if (b.count >= 4'd8) begin
      h = mul_k(h ^ mul_k(shift_fold(mul_k(b.word))));
    end else if (b.count != 4'd0) begin
      keep = (64'd1 << (8 * b.count)) - 64'd1;
      h = mul_k(h ^ (b.word & keep));
    end
    chain_hash = h;
    digest = shift_fold(mul_k(shift_fold(h)));
    return b.last;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch %s: expected %016h, got %016h", what, exp_v, act_v);
  endtask

  // Receiver: drop ready at random
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result beat with the oldest pending hash
  always @(posedge clk) begin
    logic [63:0] exp_v;
    if (rst_n && out_if.valid && out_if.ready) begin
      hashes_seen++;
      if (pending_hash_q.size() == 0) begin
        note_mismatch("unexpected hash beat", 64'd0, out_if.hash_value);
      end else begin
        exp_v = pending_hash_q.pop_front();
        if (out_if.hash_value !== exp_v) note_mismatch("hash_value", exp_v, out_if.hash_value);
      end
    end
  end

  // Drive one beat, with a random gap first; valid stays high for back-to-back beats
  task automatic send_beat(input word_beat_t b);
    logic [63:0] digest;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_if.first        <= b.first;
    in_if.data_word    <= b.word;
    in_if.byte_count   <= b.count;
    in_if.last         <= b.last;
    in_if.total_length <= b.length;
    in_if.valid        <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    beats_sent++;
    if (fold_beat(b, digest)) pending_hash_q.push_back(digest);
  endtask

  function automatic word_beat_t mk_beat(input logic first, input logic [63:0] word,
                                         input logic [3:0] count, input logic last,
                                         input logic [31:0] length);
    word_beat_t b;
    b.first  = first;
    b.word   = word;
    b.count  = count;
    b.last   = last;
    b.length = length;
    return b;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Send a message of len bytes as full words and a tail; upper tail bytes are junk
  task automatic send_message(input int unsigned len, input logic [31:0] length_field,
                              input logic with_first);
    int unsigned left;
    int unsigned cnt;
    logic        at_start;
    left = len;
    at_start = 1'b1;
    if (len == 0) begin
      send_beat(mk_beat(with_first, rand64(), 4'd0, 1'b1, length_field));
    end else begin
      while (left > 0) begin
        cnt = (left >= 8) ? 8 : left;
        left -= cnt;
        send_beat(mk_beat(at_start & with_first, rand64(), 4'(cnt), left == 0,
                          length_field));
        at_start = 1'b0;
      end
    end
  endtask

  // Lower valid, wait out every pending hash, then let the core settle
  task automatic drain_block();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_hash_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == SEED_ADDR) seed_shadow = value;
    seeds_written++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_check_seed();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SEED_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== seed_shadow) note_mismatch("seed readback", seed_shadow, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_seed(input logic [63:0] value);
    drain_block();
    cfg_write(SEED_ADDR, value);
    cfg_check_seed();
  endtask

  // Reset values and messages with no first beat
  task automatic test_reset_state();
    cfg_check_seed();
    send_beat(mk_beat(1'b0, rand64(), 4'd8, 1'b1, $urandom));
    send_beat(mk_beat(1'b0, rand64(), 4'd5, 1'b1, $urandom));
  endtask

  // Field extremes and the special cases of the stream format
  task automatic test_special_cases();
    // empty message
    send_beat(mk_beat(1'b1, rand64(), 4'd0, 1'b1, 32'd0));
    // full words with all-ones and all-zero data
    send_beat(mk_beat(1'b1, '1, 4'd8, 1'b1, 32'd8));
    send_beat(mk_beat(1'b1, '0, 4'd8, 1'b1, 32'd8));
    // byte counts above eight
    send_beat(mk_beat(1'b1, rand64(), 4'd9, 1'b1, 32'd8));
    send_beat(mk_beat(1'b1, rand64(), 4'd15, 1'b1, 32'd8));
    // shortest and longest tails with junk in the masked bytes
    send_beat(mk_beat(1'b1, '1, 4'd1, 1'b1, 32'd1));
    send_beat(mk_beat(1'b1, '1, 4'd7, 1'b1, 32'd7));
    // tail that is not last
    send_beat(mk_beat(1'b1, rand64(), 4'd3, 1'b0, 32'd11));
    send_beat(mk_beat(1'b0, rand64(), 4'd8, 1'b1, 32'd11));
    // zero-count beat in mid message passes the hash through
    send_beat(mk_beat(1'b1, rand64(), 4'd8, 1'b0, 32'd12));
    send_beat(mk_beat(1'b0, rand64(), 4'd0, 1'b0, 32'd12));
    send_beat(mk_beat(1'b0, rand64(), 4'd4, 1'b1, 32'd12));
    // largest length field, not matching the bytes sent
    send_beat(mk_beat(1'b1, rand64(), 4'd0, 1'b1, '1));
    // first in mid message restarts the hash
    send_beat(mk_beat(1'b1, rand64(), 4'd8, 1'b0, 32'd16));
    send_beat(mk_beat(1'b1, rand64(), 4'd8, 1'b1, 32'd8));
    // continue after a last beat without first
    send_beat(mk_beat(1'b0, rand64(), 4'd2, 1'b1, 32'd0));
  endtask

  // Seed at both ends of its range and with only its top and bottom bits set
  task automatic test_seed_extremes();
    set_seed('1);
    send_message(12, 32'd12, 1'b1);
    set_seed(64'h8000_0000_0000_0001);
    send_message(8, 32'd8, 1'b1);
    set_seed('0);
    send_message(0, 32'd0, 1'b1);
  endtask

  // Mostly well-formed messages, some with a wrong length or no first, plus noise
  task automatic test_random_traffic(input logic [63:0] seed_value, input int unsigned s_pct,
                                     input int unsigned r_pct, input int unsigned n_beats);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    set_seed(seed_value);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(200, 41) : $urandom_range(40);
      if (pick < 78) begin
        send_message(len, 32'(len), 1'b1);
      end else if (pick < 86) begin
        send_message(len, $urandom, 1'b1);
      end else if (pick < 90) begin
        send_message(len, 32'(len), 1'b0);
      end else begin
        send_beat(mk_beat(1'($urandom_range(1)), rand64(), 4'($urandom_range(15)),
                          1'($urandom_range(1)), $urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.first = 1'b0;
    in_if.data_word = '0;
    in_if.byte_count = '0;
    in_if.last = 1'b0;
    in_if.total_length = '0;
    out_if.ready = 1'b0;
    seed_shadow = '0;
    chain_hash = '0;
    beats_sent = 0;
    hashes_seen = 0;
    seeds_written = 0;
    err_count = 0;
    send_idle_pct = 26;
    recv_idle_pct = 76;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_special_cases();
    test_seed_extremes();
    test_random_traffic(rand64(), 26, 76, 560);
    test_random_traffic('1, 76, 26, 560);
    test_random_traffic('0, 0, 0, 560);
    drain_block();

    if (pending_hash_q.size() != 0)
      note_mismatch("hashes never delivered", 64'(pending_hash_q.size()), 64'd0);
    $display("run covered %0d input beats and %0d hash beats over %0d seed writes",
             beats_sent, hashes_seen, seeds_written);
    $display("three idle profiles; %0d mismatches", err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
